// File: hw/rtl/fir_filter_mac_defines.svh
// ----------------------------------------------------------------------------
// fir_filter_mac_defines.svh
// Assertion macros for the FIR filter RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_MAC_DEFINES_SVH
`define FIR_FILTER_MAC_DEFINES_SVH

`ifndef SYNTHESIS
`define FIR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FIR_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`else
`define FIR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FIR_ASSERT_ALWAYS(lbl, clk, rst, prop)
`endif

`endif

// File: hw/rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared widths, opcodes and register indexes of the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int OPCODE_W     = 2;
  localparam int COEF_INDEX_W = 7;
  localparam int TAP_COUNT_W  = 8;
  localparam int SHIFT_W      = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [OPCODE_W-1:0] OP_FILTER    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_SHIFT = 2'd1;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST    = 8'd101;
  localparam logic [SHIFT_W-1:0]     RESULT_SHIFT_RST = 5'd15;

endpackage

// File: hw/rtl/fir_in_if.sv
// ----------------------------------------------------------------------------
// fir_in_if
// Input word channel: opcode, sample and coefficient load fields.
// ----------------------------------------------------------------------------
interface fir_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) ();
  import fir_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OPCODE_W-1:0]           opcode;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [COEF_INDEX_W-1:0]       coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  modport source (output valid, opcode, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, opcode, sample_in, coef_index, coef_value, output ready);
endinterface

// File: hw/rtl/fir_out_if.sv
// ----------------------------------------------------------------------------
// fir_out_if
// Result word channel: filtered sample and saturation flag.
// ----------------------------------------------------------------------------
interface fir_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// File: hw/rtl/fir_cfg_if.sv
// ----------------------------------------------------------------------------
// fir_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fir_cfg_if ();
  import fir_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/fir_filter_mac.sv
// ----------------------------------------------------------------------------
// fir_filter_mac
// Direct-form FIR filter built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Channels: items (opcode word in), results (filtered word out), cfg (register
// writes: index 0 tap_count, index 1 result_shift; always ready).
// Opcode 0 pushes a sample and produces one result word; opcode 1 loads one
// coefficient; opcode 2 clears the sample history; opcode 3 does nothing.
// Non-filter words keep the block in S_IDLE. A filter word runs the MAC once
// per tap: n = min(tap_count, MAX_TAPS, samples since last clear). The result
// word passes S_RUN, S_DRAIN and S_SHIFT (S_RUN and S_DRAIN are skipped when
// n = 0) and is loaded into the output register in S_OUT; the next word is
// accepted only after that load. The MAC loop reads one coefficient and one
// history sample per cycle.
// items.ready is high only between filter words.
// Reset: registers take their defaults and the coefficient store is swept
// to zero; no input word is accepted until the sweep is done.
// Output stall: a finished result waits in the output register while new
// words are accepted; the next filter result holds until that register frees.
// ----------------------------------------------------------------------------
`include "fir_filter_mac_defines.svh"

module fir_filter_mac #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  fir_in_if.sink    items,
  fir_out_if.source results,
  fir_cfg_if.sink   cfg
);
  import fir_pkg::*;

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = (CNT_W > TAP_COUNT_W) ? CNT_W : TAP_COUNT_W;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + AW;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [SAMPLE_BITS-1:0] OUT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_LO = ~OUT_HI;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RUN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SHIFT = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [TAP_COUNT_W-1:0] tap_count;
  logic [SHIFT_W-1:0]     result_shift;

  logic [AW-1:0]    init_addr;
  logic [AW-1:0]    newest;
  logic [AW-1:0]    pos_next;
  logic [AW-1:0]    rd_pos;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_eff_next;
  logic [CNT_W-1:0] j;
  logic             rd_vld;
  logic             mul_vld;

  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic signed [PROD_W-1:0]      product;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       shifted;

  logic             in_acc;
  logic             coef_ok;
  logic [AW-1:0]    coef_addr;
  logic             out_load;
  logic [CMP_W-1:0] taps_lim;
  logic [CMP_W-1:0] fill_cmp;

  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = items.valid && items.ready;
  assign coef_ok     = (32'(items.coef_index) < MAX_TAPS);
  assign coef_addr   = AW'(items.coef_index);
  assign out_load    = (state == S_OUT) && (!results.valid || results.ready);

  assign pos_next  = (newest == AW'(MAX_TAPS - 1)) ? '0 : newest + 1'b1;
  assign fill_next = (fill == CNT_W'(MAX_TAPS)) ? fill : fill + 1'b1;

  always_comb begin
    taps_lim = (CMP_W'(tap_count) > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS)
                                                       : CMP_W'(tap_count);
    fill_cmp = CMP_W'(fill_next);
    n_eff_next = (fill_cmp < taps_lim) ? fill_next : CNT_W'(taps_lim);
  end

  // control and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      tap_count    <= TAP_COUNT_RST;
      result_shift <= RESULT_SHIFT_RST;
      init_addr    <= '0;
      newest       <= '0;
      fill         <= '0;
      n_eff        <= '0;
      j            <= '0;
      rd_pos       <= '0;
      rd_vld       <= 1'b0;
      mul_vld      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_TAP_COUNT:    tap_count    <= cfg.data[TAP_COUNT_W-1:0];
          CFG_RESULT_SHIFT: result_shift <= cfg.data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      rd_vld  <= 1'b0;
      mul_vld <= rd_vld;
      unique case (state)
        S_INIT: begin
          init_addr <= init_addr + 1'b1;
          if (init_addr == AW'(MAX_TAPS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (items.valid) begin
            unique case (items.opcode)
              OP_FILTER: begin
                newest <= pos_next;
                fill   <= fill_next;
                n_eff  <= n_eff_next;
                j      <= '0;
                rd_pos <= pos_next;
                state  <= (n_eff_next == '0) ? S_SHIFT : S_RUN;
              end
              OP_CLEAR: begin
                newest <= '0;
                fill   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          rd_vld <= 1'b1;
          j      <= j + 1'b1;
          rd_pos <= (rd_pos == '0) ? AW'(MAX_TAPS - 1) : rd_pos - 1'b1;
          if (j == n_eff - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_vld && !mul_vld) state <= S_SHIFT;
        end
        S_SHIFT: state <= S_OUT;
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // coefficient and history memories
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      coef_mem[init_addr] <= '0;
    end else if (in_acc && items.opcode == OP_LOAD_COEF && coef_ok) begin
      coef_mem[coef_addr] <= items.coef_value;
    end
    coef_rd <= coef_mem[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && items.opcode == OP_FILTER) begin
      hist_mem[pos_next] <= items.sample_in;
    end
    hist_rd <= hist_mem[rd_pos];
  end

  // shared MAC, then shift
  always_ff @(posedge clk) begin
    product <= coef_rd * hist_rd;
    if (state == S_IDLE) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + ACC_W'(product);
    end
    if (state == S_SHIFT) begin
      shifted <= acc >>> result_shift;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (shifted > SAT_HI) begin
        results.sample_out <= OUT_HI;
        results.saturated  <= 1'b1;
      end else if (shifted < SAT_LO) begin
        results.sample_out <= OUT_LO;
        results.saturated  <= 1'b1;
      end else begin
        results.sample_out <= shifted[SAMPLE_BITS-1:0];
        results.saturated  <= 1'b0;
      end
    end
  end

  `FIR_ASSERT_IMP(a_sat_rails, clk, rst, results.valid && results.saturated,
                  results.sample_out == OUT_HI || results.sample_out == OUT_LO)
  `FIR_ASSERT_IMP(a_tap_in_range, clk, rst, state == S_RUN, j < n_eff)
  `FIR_ASSERT_IMP(a_drained, clk, rst, state == S_SHIFT, !rd_vld && !mul_vld)
  `FIR_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= CNT_W'(MAX_TAPS))

endmodule
